// ----- rtl/clms_pkg.sv -----
// Shared types and constants for the charlieplexed LED matrix scanner.
// Holds the transfer payload structs, action codes and parameter defaults.
// No dependencies.
`default_nettype none

package clms_pkg;

    // Parameter defaults
    localparam int MATRIX_WIDTH_DEF  = 8;
    localparam int MATRIX_HEIGHT_DEF = 8;
    localparam int LEVEL_BITS_DEF    = 4;

    // Scan coordinates and pin indices always fit in four bits
    localparam int COORD_W = 4;

    // Swap fires once the distance to the target leaves this window
    localparam logic [31:0] SWAP_WINDOW = 32'h0000_FFFF;

    // Action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SWAP  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  level_in;
        logic [31:0] target_frame;
    } in_item_t;

    typedef struct packed {
        logic        drive_on;
        logic [3:0]  high_pin;
        logic [3:0]  low_pin;
        logic [31:0] frame_total;
        logic        swap_pending;
        logic        swapped_now;
        logic [31:0] swap_frame;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/charlieplex_led_matrix_scanner.sv -----
// Top level of the charlieplexed LED matrix scanner with double-buffered PWM.
// Depends on clms_pkg for payload structs, action codes and defaults.
`default_nettype none

// Usage
// - Input channel (s_valid/s_ready/s_item) carries one action per transfer:
//   scan tick, pixel write into the back buffer, back-buffer clear, or a
//   swap request with a target frame number.
// - Result channel (m_valid/m_ready/m_item) returns exactly one result per
//   input transfer, in order: pin pair and drive enable for ticks, plus the
//   frame count and swap status for every action.
// - The input transfer is held in the input register, then its result goes
//   to the result register, which drives m_valid.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the single pass from the input register through the scan/compare logic
//   to the result register; the pixel memory is read ahead at the next scan
//   position so its registered read data is ready when the tick arrives.
// - Reset (aresetn low, synchronous): scan position, level 1, frame count,
//   swap state and both buffers' valid bits clear, so every pixel reads dark.
//   No clearing pass is needed.
// - When the receiver stalls, the result register holds its item and the
//   input register takes one more item; after that s_ready drops.
module charlieplex_led_matrix_scanner
    import clms_pkg::*;
#(
    parameter int MATRIX_WIDTH  = MATRIX_WIDTH_DEF,
    parameter int MATRIX_HEIGHT = MATRIX_HEIGHT_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_valid,
    output logic       s_ready,
    input  wire in_item_t s_item,

    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_item
);

    localparam int PIX_COUNT = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int IDX_W     = $clog2(PIX_COUNT);
    localparam int BANK_ROWS = 2 ** IDX_W;

    localparam logic [COORD_W-1:0]    X_LAST    = COORD_W'(MATRIX_WIDTH - 1);
    localparam logic [COORD_W-1:0]    Y_LAST    = COORD_W'(MATRIX_HEIGHT - 1);
    localparam logic [7:0]            WIDTH_LIM = 8'(MATRIX_WIDTH);
    localparam logic [7:0]            HEIGHT_LIM = 8'(MATRIX_HEIGHT);
    localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1);

    // Input register
    in_item_t  in_reg;
    logic      in_vld_reg;

    // Result register
    out_item_t out_reg, out_next;
    logic      out_vld_reg;

    // Scanner state
    logic                  front_reg, front_next;
    logic [COORD_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [LEVEL_BITS-1:0] lvl_reg, lvl_next;
    logic [31:0]           frame_reg, frame_next;
    logic [31:0]           target_reg, target_next;
    logic                  req_reg, req_next;

    // Pixel memory: bank in the top address bit, pixel index below
    logic [LEVEL_BITS-1:0] pix_mem [2*BANK_ROWS];
    logic [1:0][BANK_ROWS-1:0] vld_reg;
    logic [LEVEL_BITS-1:0] rd_pix_reg;
    logic                  rd_vld_reg;

    logic                  advance;
    logic                  back_bank;
    logic                  wr_en;
    logic                  clr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [LEVEL_BITS-1:0] cur_pix;
    logic [COORD_W-1:0]    pin_lo;
    logic [31:0]           frame_inc;
    logic [31:0]           swap_dist;

    // Take a new item when the input register is empty or moving on
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_item    = out_reg;
    assign back_bank = ~front_reg;

    // Pixel write target: column-major index, out-of-range writes dropped
    assign wr_idx = IDX_W'(in_reg.column[COORD_W-1:0] * MATRIX_HEIGHT)
                  + IDX_W'(in_reg.row[COORD_W-1:0]);
    assign wr_en  = advance && (in_reg.action == ACT_WRITE)
                  && (in_reg.column < WIDTH_LIM) && (in_reg.row < HEIGHT_LIM);
    assign clr_en = advance && (in_reg.action == ACT_CLEAR);

    // Unwritten or cleared pixels read as dark
    assign cur_pix   = rd_vld_reg ? rd_pix_reg : '0;
    assign pin_lo    = X_LAST - col_reg;
    assign frame_inc = frame_reg + 32'd1;
    assign swap_dist = target_reg - frame_inc;

    always_comb begin
        front_next  = front_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        idx_next    = idx_reg;
        lvl_next    = lvl_reg;
        frame_next  = frame_reg;
        target_next = target_reg;
        req_next    = req_reg;
        out_next    = '0;

        if (advance) begin
            case (in_reg.action)
                ACT_TICK: begin
                    out_next.drive_on = (cur_pix >= lvl_reg);
                    out_next.low_pin  = pin_lo;
                    out_next.high_pin = (row_reg >= pin_lo) ? row_reg + 4'd1 : row_reg;

                    // Advance row inside column, column inside level, level inside frame
                    if (row_reg == Y_LAST) begin
                        row_next = '0;
                        if (col_reg == X_LAST) begin
                            col_next = '0;
                            idx_next = '0;
                            if (lvl_reg == LEVEL_TOP) begin
                                lvl_next   = LEVEL_ONE;
                                frame_next = frame_inc;
                                if (req_reg && (swap_dist > SWAP_WINDOW)) begin
                                    front_next           = back_bank;
                                    target_next          = frame_inc;
                                    req_next             = 1'b0;
                                    out_next.swapped_now = 1'b1;
                                end
                            end else begin
                                lvl_next = lvl_reg + LEVEL_ONE;
                            end
                        end else begin
                            col_next = col_reg + 4'd1;
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end else begin
                        row_next = row_reg + 4'd1;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                ACT_SWAP: begin
                    // A repeated request replaces the target and stays pending
                    target_next = in_reg.target_frame;
                    req_next    = 1'b1;
                end
                default: begin
                    // Writes and clears touch only the back buffer
                end
            endcase
            out_next.frame_total  = frame_next;
            out_next.swap_pending = req_next;
            out_next.swap_frame   = target_next;
        end
    end

    // Input and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            idx_reg    <= '0;
            lvl_reg    <= LEVEL_ONE;
            frame_reg  <= '0;
            target_reg <= '0;
            req_reg    <= 1'b0;
        end else begin
            front_reg  <= front_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            idx_reg    <= idx_next;
            lvl_reg    <= lvl_next;
            frame_reg  <= frame_next;
            target_reg <= target_next;
            req_reg    <= req_next;
        end
    end

    // Valid bits: clear whole back buffer at once, set on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (clr_en) begin
                vld_reg[back_bank] <= '0;
            end else if (wr_en) begin
                vld_reg[back_bank][wr_idx] <= 1'b1;
            end
            // Read ahead at the position the next tick will visit
            rd_vld_reg <= vld_reg[front_next][idx_next];
        end
    end

    // Pixel memory: one write port (back buffer), one registered read (front)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pix_mem[{back_bank, wr_idx}] <= in_reg.level_in[LEVEL_BITS-1:0];
        end
        rd_pix_reg <= pix_mem[{front_next, idx_next}];
    end

endmodule

`default_nettype wire

// ----- tb/charlieplex_led_matrix_scanner_test.sv -----
// Self-checking testbench for the charlieplexed LED matrix scanner.
// Drives a directed table and then random actions through valid/ready, predicts
// each result in place and compares it field by field. Depends on clms_pkg.

module charlieplex_led_matrix_scanner_test;
    import clms_pkg::*;

    localparam int WIDTH       = MATRIX_WIDTH_DEF;
    localparam int HEIGHT      = MATRIX_HEIGHT_DEF;
    localparam int PIX_COUNT   = WIDTH * HEIGHT;
    localparam int LEVEL_COUNT = 1 << LEVEL_BITS_DEF;
    localparam logic [7:0] LEVEL_MASK = 8'((1 << LEVEL_BITS_DEF) - 1);

    localparam int RANDOM_ITEMS = 1534;
    localparam int CYCLE_LIMIT  = 600000;
    // Receiver hold-off: start it once the sender has this many transfers in,
    // and keep m_ready low for this many cycles.
    localparam int HOLD_AT      = 520;
    localparam int HOLD_CYCLES  = 300;

    // Status of a write or clear right after reset: everything zero.
    localparam out_item_t IDLE_STATUS = '0;

    typedef struct {
        in_item_t  item;
        bit        typed;   // result below is the expected one
        out_item_t result;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 16;

    // Directed table: corners of the fields, every action, dropped writes,
    // brightness masking, repeated swap requests and the swap window edge.
    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        // first tick after reset: pixel (0,0), dark, high pin 0, low pin 7
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'd0, 4'd7, 32'd0, 1'b0, 1'b0, 32'd0}},
        '{'{ACT_WRITE, 8'h00, 8'h01, 8'hFF, 32'hFFFF_FFFF}, 1'b1, IDLE_STATUS},
        '{'{ACT_WRITE, 8'h07, 8'h07, 8'h0F, 32'h0000_0000}, 1'b1, IDLE_STATUS},
        // out of range column, then out of range row: dropped
        '{'{ACT_WRITE, 8'h08, 8'h00, 8'hF0, 32'h0000_0000}, 1'b1, IDLE_STATUS},
        '{'{ACT_WRITE, 8'h00, 8'h08, 8'hAA, 32'h0000_0000}, 1'b1, IDLE_STATUS},
        '{'{ACT_WRITE, 8'hFF, 8'hFF, 8'h55, 32'hFFFF_FFFF}, 1'b1, IDLE_STATUS},
        '{'{ACT_TICK,  8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b0, IDLE_STATUS},
        // swap request, then a second one overwriting the target
        '{'{ACT_SWAP,  8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 4'd0, 4'd0, 32'd0, 1'b1, 1'b0, 32'hFFFF_FFFF}},
        '{'{ACT_SWAP,  8'h00, 8'h00, 8'h00, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'd0, 4'd0, 32'd0, 1'b1, 1'b0, 32'd0}},
        '{'{ACT_CLEAR, 8'h5A, 8'hA5, 8'h3C, 32'h5A5A_A5A5}, 1'b0, IDLE_STATUS},
        '{'{ACT_WRITE, 8'h03, 8'h05, 8'h18, 32'h0000_0000}, 1'b0, IDLE_STATUS},
        // brightness above the mask wraps to zero
        '{'{ACT_WRITE, 8'h00, 8'h00, 8'h10, 32'h0000_0000}, 1'b0, IDLE_STATUS},
        // target just inside the window, then a tick and a target far outside it
        '{'{ACT_SWAP,  8'h00, 8'h00, 8'h00, 32'h0001_0000}, 1'b1,
          '{1'b0, 4'd0, 4'd0, 32'd0, 1'b1, 1'b0, 32'h0001_0000}},
        '{'{ACT_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000}, 1'b0, IDLE_STATUS},
        '{'{ACT_SWAP,  8'h00, 8'h00, 8'h00, 32'hFFFF_0000}, 1'b0, IDLE_STATUS},
        '{'{ACT_WRITE, 8'h07, 8'h00, 8'hFF, 32'h0000_0000}, 1'b0, IDLE_STATUS}
    };

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Shadow of the scanner: both pixel banks, scan position, level,
    // frame count and the pending swap.
    logic [3:0]  pix_mem [2][PIX_COUNT];
    logic        shown_bank;
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned cur_level;
    logic [31:0] frames_done;
    logic [31:0] pending_target;
    logic        pending_swap;

    out_item_t   scan_results_q [$];
    out_item_t   oldest_result;
    int unsigned error_count = 0;
    int unsigned sent_count  = 0;
    int unsigned cycle_count = 0;
    bit          hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;
    int unsigned hold_cycles;
    int unsigned ready_pick;

    charlieplex_led_matrix_scanner dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one accepted action to the shadow state and return its result.
    task automatic predict_scan(input in_item_t it, output out_item_t res);
        int unsigned x;
        int unsigned y;
        int unsigned px;
        int unsigned py;
        logic        back;
        logic [7:0]  masked;
        res    = '0;
        back   = ~shown_bank;
        masked = it.level_in & LEVEL_MASK;
        case (it.action)
            ACT_WRITE: begin
                // drop writes that fall outside the matrix
                if (int'(it.column) < WIDTH && int'(it.row) < HEIGHT)
                    pix_mem[back][int'(it.column) * HEIGHT + int'(it.row)] = masked[3:0];
            end
            ACT_CLEAR: begin
                for (int i = 0; i < PIX_COUNT; i++)
                    pix_mem[back][i] = 4'd0;
            end
            ACT_SWAP: begin
                pending_target = it.target_frame;
                pending_swap   = 1'b1;
            end
            default: begin
                x  = cur_col;
                y  = cur_row;
                px = WIDTH - 1 - x;
                py = (y >= px) ? y + 1 : y;
                res.drive_on = int'(pix_mem[shown_bank][x * HEIGHT + y]) >= int'(cur_level);
                res.high_pin = 4'(py);
                res.low_pin  = 4'(px);
                // advance row first, then column, then level, then frame
                y++;
                if (y == HEIGHT) begin
                    y = 0;
                    x++;
                    if (x == WIDTH) begin
                        x = 0;
                        cur_level++;
                        if (cur_level >= LEVEL_COUNT) begin
                            cur_level = 1;
                            frames_done++;
                            if (pending_swap && (pending_target - frames_done) > SWAP_WINDOW) begin
                                shown_bank      = back;
                                pending_target  = frames_done;
                                pending_swap    = 1'b0;
                                res.swapped_now = 1'b1;
                            end
                        end
                    end
                end
                cur_col = x;
                cur_row = y;
            end
        endcase
        res.frame_total  = frames_done;
        res.swap_pending = pending_swap;
        res.swap_frame   = pending_target;
    endtask

    // Mostly scan ticks so frames complete; writes land in range most of the
    // time, swap targets sit near the frame count, at the window edge or at random.
    function automatic in_item_t random_scan_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned sel;
        it.action       = ACT_TICK;
        it.column       = 8'($urandom_range(0, 255));
        it.row          = 8'($urandom_range(0, 255));
        it.level_in     = 8'($urandom_range(0, 255));
        it.target_frame = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            it.action = ACT_TICK;
        end else if (pick < 93) begin
            it.action = ACT_WRITE;
            if ($urandom_range(0, 7) != 0) begin
                it.column = 8'($urandom_range(0, WIDTH - 1));
                it.row    = 8'($urandom_range(0, HEIGHT - 1));
            end
        end else if (pick < 95) begin
            it.action = ACT_CLEAR;
        end else begin
            it.action = ACT_SWAP;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                it.target_frame = frames_done + 32'($urandom_range(0, 4)) - 32'd2;
            else if (sel < 8)
                it.target_frame = frames_done + SWAP_WINDOW + 32'($urandom_range(0, 2)) - 32'd1;
        end
        return it;
    endfunction

    // Offer one action after a random gap, hold it until the transfer, then
    // queue its expected result.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_result);
        int unsigned gap;
        int unsigned pick;
        out_item_t   predicted;
        pick = $urandom_range(0, 99);
        // keep the input busy around the receiver hold-off so the block fills up
        if (sent_count >= HOLD_AT - 20 && sent_count < HOLD_AT + 280)
            gap = 0;
        else if (pick < 70)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_scan(it, predicted);
        scan_results_q.push_back(typed ? typed_result : predicted);
        sent_count++;
        if (sent_count == HOLD_AT)
            hold_off_req = 1'b1;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Stimulus: reset, directed table, random actions, then drain and report.
    initial begin
        s_valid <= 1'b0;
        s_item  <= '0;
        aresetn <= 1'b0;
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < PIX_COUNT; i++)
                pix_mem[b][i] = 4'd0;
        shown_bank     = 1'b0;
        cur_col        = 0;
        cur_row        = 0;
        cur_level      = 1;
        frames_done    = '0;
        pending_target = '0;
        pending_swap   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_item(random_scan_item(), 1'b0, IDLE_STATUS);
        s_valid <= 1'b0;

        // drain, then wait so that any stray result can still show up
        while (scan_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls of mixed length, stretches with no stall, and
    // one long hold-off while the sender keeps offering.
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
                    @(posedge aclk);
            end else begin
                ready_pick = $urandom_range(0, 99);
                if (ready_pick < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (ready_pick < 64) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(100, 200)) @(posedge aclk);
                end else if (ready_pick < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(15, 60)) @(posedge aclk);
                end
            end
        end
    end

    // Result checker: compare each transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (scan_results_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, m_item);
                error_count++;
            end else begin
                oldest_result = scan_results_q.pop_front();
                check_field("drive_on",     32'(oldest_result.drive_on),     32'(m_item.drive_on));
                check_field("high_pin",     32'(oldest_result.high_pin),     32'(m_item.high_pin));
                check_field("low_pin",      32'(oldest_result.low_pin),      32'(m_item.low_pin));
                check_field("frame_total",  oldest_result.frame_total,       m_item.frame_total);
                check_field("swap_pending", 32'(oldest_result.swap_pending), 32'(m_item.swap_pending));
                check_field("swapped_now",  32'(oldest_result.swapped_now),  32'(m_item.swapped_now));
                check_field("swap_frame",   oldest_result.swap_frame,        m_item.swap_frame);
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, scan_results_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ----- files.f -----
rtl/clms_pkg.sv
rtl/charlieplex_led_matrix_scanner.sv
tb/charlieplex_led_matrix_scanner_test.sv
